// ===== rtl/core/hpp_pkg.sv =====
// hpp_pkg: shared types, constants and opcodes of the homogeneous point projector
// no dependencies
`default_nettype none
package hpp_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int ROW_W         = 66;   // exact row sum after floor
    localparam int NUM_COEF      = 16;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_PROJECT = 2'd1,
        OP_XFORM   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef struct packed {
        logic is_xform;
        logic last;
    } t_ctl;
endpackage
`default_nettype wire

// ===== rtl/core/hpp_rows.sv =====
// hpp_rows: evaluates the four transformed rows of a point in three stages
// depends on hpp_pkg
`default_nettype none
module hpp_rows #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire hpp_pkg::t_ctl                  i_ctl,
    input  wire logic signed [31:0]             i_x,
    input  wire logic signed [31:0]             i_y,
    input  wire logic signed [31:0]             i_z,
    input  wire logic [15:0][31:0]              i_coef,
    output logic                                o_valid,
    output hpp_pkg::t_ctl                       o_ctl,
    output logic signed [hpp_pkg::ROW_W-1:0]    o_num,
    output logic signed [hpp_pkg::ROW_W-1:0]    o_ny,
    output logic signed [hpp_pkg::ROW_W-1:0]    o_nz,
    output logic signed [hpp_pkg::ROW_W-1:0]    o_den
);
    import hpp_pkg::*;

    // stage a: products (12 multipliers, one per coefficient of the first three columns)
    logic                   r_va;
    t_ctl                   r_ca;
    logic signed [63:0]     r_p [4][3];
    logic signed [31:0]     r_k [4];
    // stage b: exact sums
    logic                   r_vb;
    t_ctl                   r_cb;
    logic signed [66:0]     r_s [4];
    logic signed [66:0]     n_s [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ca <= i_ctl;
            r_cb <= r_ca;
            for (int r = 0; r < 4; r++) begin
                r_p[r][0] <= $signed(i_coef[r*4+0]) * i_x;
                r_p[r][1] <= $signed(i_coef[r*4+1]) * i_y;
                r_p[r][2] <= $signed(i_coef[r*4+2]) * i_z;
                r_k[r]    <= $signed(i_coef[r*4+3]);
                r_s[r]    <= n_s[r];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_s[r] = 67'(r_p[r][0]) + 67'(r_p[r][1]) + 67'(r_p[r][2])
                   + (67'(r_k[r]) <<< FRAC_BITS);
        end
    end

    // stage c: floor to FRAC_BITS fraction bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl <= r_cb;
            o_num <= ROW_W'(r_s[0] >>> FRAC_BITS);
            o_ny  <= ROW_W'(r_s[1] >>> FRAC_BITS);
            o_nz  <= ROW_W'(r_s[2] >>> FRAC_BITS);
            o_den <= r_cb.is_xform ? ROW_W'(r_s[3] >>> FRAC_BITS)
                                   : ROW_W'(r_s[2] >>> FRAC_BITS);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/hpp_div.sv =====
// hpp_div: pipelined restoring divider, one quotient bit per stage, with saturation
// depends on hpp_pkg
`default_nettype none
module hpp_div #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic signed [hpp_pkg::ROW_W-1:0] i_num,
    input  wire logic signed [hpp_pkg::ROW_W-1:0] i_den,
    output logic                                o_valid,
    output logic [31:0]                         o_q
);
    import hpp_pkg::*;

    // quotient bits needed before saturation: 32 plus one overflow bit
    localparam int QB = 33;
    localparam int NW = ROW_W + FRAC_BITS;   // magnitude of shifted numerator
    localparam int RW = ROW_W + 1;

    logic             r_v   [QB+1];
    logic             r_neg [QB+1];
    logic             r_ovf [QB+1];
    logic [QB-1:0]    r_n   [QB+1];
    logic [ROW_W-1:0] r_d   [QB+1];
    logic [RW-1:0]    r_r   [QB+1];
    logic [QB-1:0]    r_q   [QB+1];

    logic [ROW_W-1:0] n_an;
    logic [ROW_W-1:0] n_ad;
    logic [NW-1:0]    n_sh;
    logic [NW-1:0]    n_hi;

    always_comb begin
        n_an = i_num[ROW_W-1] ? ROW_W'(-i_num) : ROW_W'(i_num);
        n_ad = i_den[ROW_W-1] ? ROW_W'(-i_den) : ROW_W'(i_den);
        n_sh = NW'(n_an) << FRAC_BITS;
        // bits above the top QB quotient bits: quotient surely overflows if n >> QB >= d
        n_hi = n_sh >> QB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= QB; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [RW-1:0] t;
        if (i_en) begin
            r_neg[0] <= i_num[ROW_W-1] ^ i_den[ROW_W-1];
            r_ovf[0] <= (n_hi >= NW'(n_ad));
            r_n[0]   <= n_sh[QB-1:0];
            r_d[0]   <= n_ad;
            r_r[0]   <= RW'(n_hi);
            r_q[0]   <= '0;
            for (int s = 1; s <= QB; s++) begin
                t = {r_r[s-1][RW-2:0], r_n[s-1][QB-s]};
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
                r_n[s]   <= r_n[s-1];
                r_d[s]   <= r_d[s-1];
                if (t >= RW'(r_d[s-1])) begin
                    r_r[s] <= t - RW'(r_d[s-1]);
                    r_q[s] <= {r_q[s-1][QB-2:0], 1'b1};
                end else begin
                    r_r[s] <= t;
                    r_q[s] <= {r_q[s-1][QB-2:0], 1'b0};
                end
            end
        end
    end

    // the bits of n above the low QB seed the remainder; when they already reach d
    // the quotient needs more than QB bits and the overflow flag takes over
    logic [QB-1:0] n_lim;
    logic [QB-1:0] n_mag;
    always_comb begin
        n_lim = r_neg[QB] ? QB'(33'h080000000) : QB'(33'h07FFFFFFF);
        n_mag = (r_ovf[QB] || r_q[QB] > n_lim) ? n_lim : r_q[QB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= r_neg[QB] ? 32'(-n_mag) : 32'(n_mag);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/homogeneous_point_projector.sv =====
// homogeneous_point_projector: top level, coefficient bank, row pipeline, three dividers
// depends on hpp_pkg, hpp_rows, hpp_div
`default_nettype none
// Streaming 4x4 homogeneous transform with perspective divide. Each transfer carries
// an op: op 0 writes one Q16.16 coefficient (row-major index) and yields nothing,
// op 1 projects (x,y,z) giving row0/row2 and row1/row2 with out_z zero, op 2 gives
// rows 0..2 divided by row 3, op 3 is dropped. Coefficients reset to identity.
// A zero divisor returns zeros with divide_by_zero set; quotients saturate to 32 bits.
// One item is accepted every cycle while the output register is empty or being taken;
// results pass through 3 row stages, 35 divider stages and the output register.
// A coefficient write takes effect for every item accepted after it.
// The whole pipeline advances whenever the output register is empty or being taken.
module homogeneous_point_projector #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: coef_index[3:0], coef_value[35:4], x[67:36], y[99:68], z[131:100]
    input  wire logic [135:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]    s_axis_tuser,
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // tdata: out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]        m_axis_tdata,
    // tuser: divide_by_zero[0]
    output logic               m_axis_tuser,
    output logic               m_axis_tlast
);
    import hpp_pkg::*;

    localparam int DLAT = 35;   // divider: input reg, 33 bit stages, output reg

    logic            w_en;
    logic            w_acc;
    t_op             w_op;
    logic [15:0][31:0] r_coef;
    logic            w_pt;
    t_ctl            w_ctl;

    // pipeline holds still only while the output holds a result not yet taken
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);
    assign w_pt          = w_acc && (w_op == OP_PROJECT || w_op == OP_XFORM);
    assign w_ctl         = '{is_xform: (w_op == OP_XFORM), last: s_axis_tlast};

    // coefficient bank, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++)
                r_coef[i] <= (i % 5 == 0) ? 32'(1) << FRAC_BITS : '0;
        end else if (w_acc && w_op == OP_WRITE) begin
            r_coef[s_axis_tdata[3:0]] <= s_axis_tdata[35:4];
        end
    end

    logic                    w_rv;
    t_ctl                    w_rc;
    logic signed [ROW_W-1:0] w_nx, w_ny, w_nz, w_den;

    hpp_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_pt), .i_ctl(w_ctl),
        .i_x(s_axis_tdata[67:36]), .i_y(s_axis_tdata[99:68]),
        .i_z(s_axis_tdata[131:100]), .i_coef(r_coef),
        .o_valid(w_rv), .o_ctl(w_rc),
        .o_num(w_nx), .o_ny(w_ny), .o_nz(w_nz), .o_den(w_den)
    );

    // side pipe for control next to the dividers
    logic r_sv [DLAT];
    t_ctl r_sc [DLAT];
    logic r_sz [DLAT];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sc[0] <= w_rc;
            r_sz[0] <= (w_den == '0);
            for (int s = 1; s < DLAT; s++) begin
                r_sc[s] <= r_sc[s-1];
                r_sz[s] <= r_sz[s-1];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DLAT; s++) r_sv[s] <= 1'b0;
        end else if (w_en) begin
            r_sv[0] <= w_rv;
            for (int s = 1; s < DLAT; s++) r_sv[s] <= r_sv[s-1];
        end
    end

    logic        w_dv0, w_dv1, w_dv2;
    logic [31:0] w_qx, w_qy, w_qz;
    // a zero divisor is replaced by one; the result is then masked
    logic signed [ROW_W-1:0] w_dsafe;
    assign w_dsafe = (w_den == '0) ? ROW_W'(1) : w_den;

    hpp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_rv),
        .i_num(w_nx), .i_den(w_dsafe), .o_valid(w_dv0), .o_q(w_qx));
    hpp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_rv),
        .i_num(w_ny), .i_den(w_dsafe), .o_valid(w_dv1), .o_q(w_qy));
    hpp_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_rv),
        .i_num(w_nz), .i_den(w_dsafe), .o_valid(w_dv2), .o_q(w_qz));

    // output register
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_sv[DLAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        logic dz;
        dz = r_sz[DLAT-1];
        if (w_en) begin
            m_axis_tdata[31:0]   <= dz ? '0 : w_qx;
            m_axis_tdata[63:32]  <= dz ? '0 : w_qy;
            m_axis_tdata[95:64]  <= (dz || !r_sc[DLAT-1].is_xform) ? '0 : w_qz;
            m_axis_tuser         <= dz;
            m_axis_tlast         <= r_sc[DLAT-1].last;
        end
    end
    assign m_axis_tvalid = r_ov;

    // divider lanes stay in step with the control pipe
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dv0 == r_sv[DLAT-1]) && (w_dv1 == w_dv0) && (w_dv2 == w_dv0))
        else $error("divider lanes out of step");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("stalled result changed");
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero divisor result not cleared");
endmodule
`default_nettype wire

// ===== verif/tb_homogeneous_point_projector.sv =====
// tb_homogeneous_point_projector: self-checking stream testbench of the point projector
// depends on hpp_pkg and homogeneous_point_projector
`timescale 1ns / 1ps

module tb_homogeneous_point_projector;
    import hpp_pkg::*;

    localparam int FB        = 16;
    localparam int CYC_LIMIT = 200000;
    // busy and hold-off windows, counted in cycles
    localparam int BUSY_FROM = 500;
    localparam int BUSY_TO   = 1000;
    localparam int HOLD_FROM = 1200;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        t_op         op;
        logic [3:0]  idx;
        logic [31:0] cval;
        logic [31:0] px, py, pz;
        logic        last;
    } t_item;

    typedef struct {
        logic [31:0] qx, qy, qz;
        logic        dz;
        logic        last;
    } t_point_out;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    t_item              item_fifo[$];
    t_point_out         want_fifo[$];
    logic signed [31:0] matrix[16];
    t_item              cur;
    int                 cycles = 0;
    int                 hold_left = 0;
    int                 errors = 0;
    int                 n_points = 0;
    int                 n_dz = 0;
    int                 n_writes = 0;

    homogeneous_point_projector #(.FRAC_BITS(FB)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // coef_index, coef_value, x, y, z
        .s_axis_tuser  (s_tuser),   // op
        .s_axis_tlast  (s_tlast),   // last_point
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // out_x, out_y, out_z
        .m_axis_tuser  (m_tuser),   // divide_by_zero
        .m_axis_tlast  (m_tlast)    // last_out
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // exact row sum, floored to FB fraction bits, plus the offset column
    function automatic logic signed [65:0] row_sum(int r, logic signed [31:0] x,
                                                   logic signed [31:0] y,
                                                   logic signed [31:0] z);
        logic signed [95:0] s;
        s = 96'(matrix[r*4]) * 96'(x) + 96'(matrix[r*4+1]) * 96'(y)
            + 96'(matrix[r*4+2]) * 96'(z);
        s = (s >>> FB) + 96'(matrix[r*4+3]);
        return s[65:0];
    endfunction

    // (num << FB) / den truncated toward zero, clamped to 32 bits
    function automatic logic [31:0] sat_quot(logic signed [65:0] num,
                                             logic signed [65:0] den);
        logic signed [127:0] n;
        logic signed [127:0] q;
        n = 128'(num) <<< FB;
        q = n / 128'(den);
        if (q > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (q < -128'sh8000_0000) return 32'h8000_0000;
        return q[31:0];
    endfunction

    // update the coefficient copy or queue the expected point for one accepted item
    task automatic project_item(input t_item it);
        logic signed [65:0] rx, ry, rz, rh, den;
        t_point_out         o;
        if (it.op == OP_WRITE) begin
            matrix[it.idx] = it.cval;
            n_writes++;
        end else if (it.op != OP_NONE) begin
            rx = row_sum(0, it.px, it.py, it.pz);
            ry = row_sum(1, it.px, it.py, it.pz);
            rz = row_sum(2, it.px, it.py, it.pz);
            rh = row_sum(3, it.px, it.py, it.pz);
            den = (it.op == OP_PROJECT) ? rz : rh;
            o.dz = (den == 0);
            o.last = it.last;
            if (o.dz) begin
                o.qx = '0; o.qy = '0; o.qz = '0;
            end else begin
                o.qx = sat_quot(rx, den);
                o.qy = sat_quot(ry, den);
                o.qz = (it.op == OP_XFORM) ? sat_quot(rz, den) : '0;
            end
            want_fifo.push_back(o);
        end
    endtask

    // sender: drives the next queued item, idling at random outside the busy window
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) project_item(cur);
            if (!s_tvalid || s_tready) begin
                if (item_fifo.size() > 0 && ((cycles >= BUSY_FROM && cycles < BUSY_TO)
                        || $urandom_range(99) >= 25)) begin
                    cur = item_fifo.pop_front();
                    s_tdata  <= {4'b0000, cur.pz, cur.py, cur.px, cur.cval, cur.idx};
                    s_tuser  <= cur.op;
                    s_tlast  <= cur.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness: random stalls, a long hold-off, and a busy window
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (cycles == HOLD_FROM) begin
            hold_left = HOLD_LEN - 1;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (cycles >= BUSY_FROM && cycles < BUSY_TO) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 25);
        end
    end

    // monitor: compare each result transfer against the oldest expected point
    always @(posedge i_clk) begin
        t_point_out w;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (want_fifo.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer %h", m_tdata);
            end else begin
                w = want_fifo.pop_front();
                n_points++;
                if (w.dz) n_dz++;
                if (m_tdata[31:0] !== w.qx || m_tdata[63:32] !== w.qy
                        || m_tdata[95:64] !== w.qz || m_tuser !== w.dz
                        || m_tlast !== w.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h dz=%b last=%b, got x=%h y=%h z=%h dz=%b last=%b",
                                 w.qx, w.qy, w.qz, w.dz, w.last, m_tdata[31:0],
                                 m_tdata[63:32], m_tdata[95:64], m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout with %0d results outstanding", want_fifo.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_write(input int idx, input logic [31:0] v);
        t_item it;
        it = '{OP_WRITE, idx[3:0], v, $urandom, $urandom, $urandom, 1'($urandom)};
        item_fifo.push_back(it);
    endtask

    task automatic push_point(input t_op op, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic last);
        t_item it;
        it = '{op, 4'($urandom), $urandom, x, y, z, last};
        item_fifo.push_back(it);
    endtask

    // mostly modest Q16.16 values so quotients land in range, sometimes anything
    function automatic logic [31:0] rnd_val(int span);
        if ($urandom_range(9) == 0) return $urandom;
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    initial begin
        int   n;
        int   len;
        t_op  op;
        for (int i = 0; i < 16; i++) matrix[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity transform, extremes, zero divisors, unused op, coefficient 13
        push_point(OP_XFORM, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 1'b0);
        push_point(OP_XFORM, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        push_point(OP_PROJECT, 32'h0003_0000, 32'h0004_0000, 32'h0, 1'b1);   // planar: z row zero
        push_point(OP_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
        push_point(OP_PROJECT, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 1'b1);
        push_point(OP_NONE, 32'h1234_5678, 32'h0, 32'h0, 1'b1);
        push_write(13, 32'h0000_8000);
        push_point(OP_XFORM, 32'h0002_0000, 32'h0004_0000, 32'h0001_0000, 1'b0);
        push_write(15, 32'h0);
        push_write(13, 32'h0);
        push_point(OP_XFORM, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 1'b1); // row 3 zero
        push_write(0, 32'h7FFF_FFFF);
        push_write(3, 32'h8000_0000);
        push_write(15, 32'h0000_0001);
        push_point(OP_XFORM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        push_point(OP_XFORM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        push_write(14, 32'hFFFF_FFFF);
        push_point(OP_PROJECT, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 1'b0);
        push_point(OP_XFORM, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 1'b1);

        // sender pause until everything issued so far has come back
        while (item_fifo.size() > 0 || s_tvalid || want_fifo.size() > 0) @(negedge i_clk);

        // random: load a matrix, stream a batch of points, with some noise items
        n = 0;
        while (n < 1650) begin
            if ($urandom_range(3) == 0) begin
                for (int i = 0; i < 16; i++) push_write(i, rnd_val(4 << FB));
                n += 16;
            end else if ($urandom_range(5) == 0) begin
                push_write($urandom_range(15), ($urandom_range(3) == 0) ? 32'h0 : rnd_val(8 << FB));
                n++;
            end
            if ($urandom_range(15) == 0) begin
                push_point(OP_NONE, $urandom, $urandom, $urandom, 1'($urandom));
                n++;
            end
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++) begin
                op = ($urandom_range(1) == 0) ? OP_PROJECT : OP_XFORM;
                push_point(op, rnd_val(256 << FB), rnd_val(256 << FB),
                           ($urandom_range(4) == 0) ? 32'h0 : rnd_val(256 << FB),
                           i == len - 1);
                n++;
            end
        end

        while (item_fifo.size() > 0 || s_tvalid) @(negedge i_clk);
        while (want_fifo.size() > 0) @(negedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("covered %0d coefficient writes and %0d points, %0d with zero divisor",
                 n_writes, n_points, n_dz);
        $display("receiver hold-off of %0d cycles and a sender drain pause exercised", HOLD_LEN);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end
endmodule
